// ===== rtl/core/key_value_hash_table_assert.svh =====
// Assertion macros shared by the RTL that checks itself.
`ifndef KEY_VALUE_HASH_TABLE_ASSERT_SVH
`define KEY_VALUE_HASH_TABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KVHT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KVHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/kvht_pkg.sv =====
package kvht_pkg;

  localparam int KEY_W       = 31;
  localparam int VAL_W       = 31;
  localparam int OUT_W       = 32;
  localparam int BUCKETS_DEF = 128;
  localparam int WAYS_DEF    = 4;

  typedef enum logic [1:0] {
    CMD_PUT    = 2'd0,
    CMD_GET    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CMP,
    ST_RESP
  } state_t;

endpackage

// ===== rtl/core/kvht_rem.sv =====
// Bucket index: key modulo BUCKETS by reciprocal multiplication. The quotient
// is formed and registered first; the next step multiplies it back and subtracts.
// A power-of-two bucket count takes the low key bits directly.
module kvht_rem import kvht_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [KEY_W-1:0]           key,
  output logic                       done,
  output logic [$clog2(BUCKETS)-1:0] rem
);

  localparam int              BW         = $clog2(BUCKETS);
  localparam bit              POW2       = (BUCKETS & (BUCKETS - 1)) == 0;
  localparam int              SH         = KEY_W + BW;
  localparam int              RW         = KEY_W + 2;
  localparam int              PW         = KEY_W + RW;
  // ceil(2^SH / BUCKETS): exact quotient for every key below 2^KEY_W.
  localparam logic [63:0]     RECIP_FULL = ((64'd1 << SH) + 64'(BUCKETS) - 64'd1)
                                           / 64'(BUCKETS);
  localparam logic [RW-1:0]   RECIP      = RECIP_FULL[RW-1:0];
  localparam logic [BW-1:0]   MOD_LO     = BW'(BUCKETS);

  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [BW-1:0]   q_r, q_nxt;
  logic [BW-1:0]   klo_r, klo_nxt;
  logic [BW-1:0]   rem_r, rem_nxt;
  logic [PW-1:0]   prod;
  logic [2*BW-1:0] qd;

  always_comb begin
    prod     = key * RECIP;
    qd       = q_r * MOD_LO;
    busy_nxt = 1'b0;
    done_nxt = 1'b0;
    q_nxt    = q_r;
    klo_nxt  = klo_r;
    rem_nxt  = rem_r;
    if (start) begin
      klo_nxt = key[BW-1:0];
      if (POW2) begin
        rem_nxt  = key[BW-1:0];
        done_nxt = 1'b1;
      end else begin
        // Only the low quotient bits matter: the remainder fits in BW bits.
        q_nxt    = prod[SH +: BW];
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      rem_nxt  = klo_r - qd[BW-1:0];
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    klo_r <= klo_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/core/key_value_hash_table.sv =====
// Key-value store with BUCKETS buckets of WAYS slots each. Every input word
// carries a command (put, get, remove), a key and a value, and yields exactly
// one result word: value_out, found and full_res. The bucket is the key
// modulo BUCKETS. Put overwrites the value of a stored key or fills the
// lowest free slot of the bucket; when the bucket has no free slot the put is
// refused with full_res set. Get returns the stored value, or -1 with found
// clear. Remove frees the slot of the key. The block works on one word at a
// time: in_ready is high only while it is idle. A word is accepted, then the
// bucket index is taken from the low key bits when BUCKETS is a power of two
// (otherwise a reciprocal multiply forms the quotient, then a multiply and
// subtract gives the remainder). Each slot scanned takes one registered
// memory read and one key compare on the single comparator, up to WAYS slots,
// stopping at the first hit; last the result is written back and loaded,
// held while the output register stays full. The result sits in an output
// register, so the next word is taken while it waits. After reset the slot
// valid map is cleared one bucket row per cycle, during which in_ready stays
// low.
`include "key_value_hash_table_assert.svh"

module key_value_hash_table import kvht_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int WAYS    = WAYS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_cmd,
  input  logic [KEY_W-1:0]        in_key,
  input  logic [VAL_W-1:0]        in_value_in,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [OUT_W-1:0] out_value_out,
  output logic                    out_found,
  output logic                    out_full_res
);

  localparam int BW    = $clog2(BUCKETS);
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOTS = BUCKETS << WW;
  localparam int SW    = KEY_W + VAL_W;

  // Valid map, one row of WAYS bits per bucket; key/value slots, one per way.
  logic [WAYS-1:0] row_mem [BUCKETS];
  logic [SW-1:0]   slot_mem [SLOTS];

  state_t          state_r, state_nxt;
  cmd_t            cmd_r, cmd_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [BW-1:0]   bucket_r, bucket_nxt;
  logic [BW-1:0]   clr_r, clr_nxt;
  logic [WW-1:0]   way_r, way_nxt;
  logic [WW-1:0]   space_r, space_nxt;
  logic            space_v_r, space_v_nxt;
  logic            hit_r, hit_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0] out_value_r, out_value_nxt;
  logic                    out_found_r, out_found_nxt;
  logic                    out_full_r, out_full_nxt;

  logic [WAYS-1:0] row_q;
  logic [SW-1:0]   slot_q;
  logic [KEY_W-1:0] slot_key_q;
  logic [VAL_W-1:0] slot_val_q;

  logic            row_rd, row_wr;
  logic [BW-1:0]   row_addr;
  logic [WAYS-1:0] row_wdata;
  logic            slot_rd, slot_wr;
  logic [WW-1:0]   slot_way;
  logic [BW+WW-1:0] slot_addr;

  logic            in_fire;
  logic            out_free;
  logic            rem_done;
  logic [BW-1:0]   rem_bucket;

  assign in_fire    = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign slot_key_q = slot_q[SW-1:VAL_W];
  assign slot_val_q = slot_q[VAL_W-1:0];
  assign slot_addr  = {bucket_r, slot_way};

  // Remainder unit: key modulo BUCKETS.
  kvht_rem #(
    .BUCKETS (BUCKETS)
  ) u_rem (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_fire),
    .key   (in_key),
    .done  (rem_done),
    .rem   (rem_bucket)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    bucket_nxt    = bucket_r;
    clr_nxt       = clr_r;
    way_nxt       = way_r;
    space_nxt     = space_r;
    space_v_nxt   = space_v_r;
    hit_nxt       = hit_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_found_nxt = out_found_r;
    out_full_nxt  = out_full_r;
    row_rd        = 1'b0;
    row_wr        = 1'b0;
    row_addr      = bucket_r;
    row_wdata     = row_q;
    slot_rd       = 1'b0;
    slot_wr       = 1'b0;
    slot_way      = way_r;
    in_ready      = (state_r == ST_IDLE);

    case (state_r)
      ST_CLR: begin
        // Sweep the valid map, one bucket row per cycle.
        row_wr    = 1'b1;
        row_addr  = clr_r;
        row_wdata = '0;
        if (clr_r == BW'(BUCKETS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = cmd_t'(in_cmd);
          key_nxt   = in_key;
          val_nxt   = in_value_in;
          state_nxt = ST_HASH;
        end
      end
      ST_HASH: begin
        way_nxt     = '0;
        space_v_nxt = 1'b0;
        hit_nxt     = 1'b0;
        if (rem_done) begin
          bucket_nxt = rem_bucket;
          state_nxt  = ST_READ;
        end
      end
      ST_READ: begin
        row_rd    = 1'b1;
        slot_rd   = 1'b1;
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        // One slot per pass through the comparator; stop at the first hit.
        if (row_q[way_r] && (slot_key_q == key_r)) begin
          hit_nxt   = 1'b1;
          state_nxt = ST_RESP;
        end else begin
          if (!row_q[way_r] && !space_v_r) begin
            space_v_nxt = 1'b1;
            space_nxt   = way_r;
          end
          if (way_r == WW'(WAYS - 1)) begin
            state_nxt = ST_RESP;
          end else begin
            way_nxt   = way_r + 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      ST_RESP: begin
        // Hold the write-back until the output register can take the result.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '1;
          out_found_nxt = 1'b0;
          out_full_nxt  = 1'b0;
          case (cmd_r)
            CMD_PUT: begin
              if (hit_r) begin
                out_found_nxt = 1'b1;
                slot_wr       = 1'b1;
              end else if (space_v_r) begin
                slot_wr   = 1'b1;
                slot_way  = space_r;
                row_wr    = 1'b1;
                row_wdata = row_q | (WAYS'(1) << space_r);
              end else begin
                out_full_nxt = 1'b1;
              end
            end
            CMD_GET: begin
              if (hit_r) begin
                out_found_nxt = 1'b1;
                out_value_nxt = {1'b0, slot_val_q};
              end
            end
            CMD_REMOVE: begin
              if (hit_r) begin
                out_found_nxt = 1'b1;
                row_wr        = 1'b1;
                row_wdata     = row_q & ~(WAYS'(1) << way_r);
              end
            end
            default: begin
            end
          endcase
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    val_r       <= val_nxt;
    bucket_r    <= bucket_nxt;
    way_r       <= way_nxt;
    space_r     <= space_nxt;
    space_v_r   <= space_v_nxt;
    hit_r       <= hit_nxt;
    out_value_r <= out_value_nxt;
    out_found_r <= out_found_nxt;
    out_full_r  <= out_full_nxt;
  end

  // Valid map memory: registered read.
  always_ff @(posedge clk) begin
    if (row_wr) begin
      row_mem[row_addr] <= row_wdata;
    end
    if (row_rd) begin
      row_q <= row_mem[row_addr];
    end
  end

  // Key/value slot memory: registered read.
  always_ff @(posedge clk) begin
    if (slot_wr) begin
      slot_mem[slot_addr] <= {key_r, val_r};
    end
    if (slot_rd) begin
      slot_q <= slot_mem[slot_addr];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_found     = out_found_r;
  assign out_full_res  = out_full_r;

  `KVHT_ASSERT_NOW(a_full_excl_found, out_valid_r && out_full_r, !out_found_r && (out_value_r == {OUT_W{1'b1}}), "full result with found or a value")
  `KVHT_ASSERT_NOW(a_miss_neg_one, out_valid_r && !out_found_r, out_value_r == {OUT_W{1'b1}}, "miss result without -1")
  `KVHT_ASSERT_NEXT(a_one_word_at_a_time, in_valid && in_ready, !in_ready, "second word taken while busy")
  `KVHT_ASSERT_NOW(a_slot_write_put_only, slot_wr, (cmd_r == CMD_PUT) && (state_r == ST_RESP), "slot written outside a put")

endmodule
